// ===== hdl/fed_pkg.sv =====
// Shared types and constants for the flag/escape deframer.
`timescale 1ns / 1ps

package fed_pkg;

	localparam int FRAME_BYTES = 1024;
	localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
	localparam int INDEX_W     = 10;
	localparam int LENGTH_W    = 11;

	localparam logic [7:0] FLAG_BYTE     = 8'h7E;
	localparam logic [7:0] ESC_BYTE      = 8'h7D;
	localparam logic [7:0] ESC_CODE_ESC  = 8'h00;
	localparam logic [7:0] ESC_CODE_FLAG = 8'h01;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              open;
		logic              esc;
	} fed_state_t;

	typedef struct packed {
		logic                dropped;
		logic                stored;
		logic [7:0]          data_byte;
		logic [INDEX_W-1:0]  write_index;
		logic                frame_done;
		logic [LENGTH_W-1:0] frame_length;
	} fed_result_t;

endpackage

// ===== hdl/flag_escape_deframer_core.sv =====
// Top level of the flag/escape byte-stuffing deframer.
`timescale 1ns / 1ps

// Takes one received link byte per transaction and gives exactly one result per byte:
// the destuffed byte with its frame index, drop and frame-done indications. Throughput is
// one byte per clock while results are accepted. Each byte passes an input register and
// then a result register; it moves into the result register, and is offered on the output,
// once the result register is free or being taken. The rate is set by the update of the
// fill/open/escape state, which every byte reads and writes. in_ready is low only while the
// input register holds a byte that cannot move on because a result waits unaccepted.
module flag_escape_deframer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          dropped,
	output logic                          stored,
	output logic [7:0]                    data_byte,
	output logic [fed_pkg::INDEX_W-1:0]   write_index,
	output logic                          frame_done,
	output logic [fed_pkg::LENGTH_W-1:0]  frame_length
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 valid_s2;
	fed_pkg::fed_result_t res_s2;
	fed_pkg::fed_state_t  state_q;
	fed_pkg::fed_state_t  state_nxt;
	fed_pkg::fed_result_t res_nxt;
	logic                 advance;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	fed_step u_step (
		.rx_byte (byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
		if (advance && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign dropped      = res_s2.dropped;
	assign stored       = res_s2.stored;
	assign data_byte    = res_s2.data_byte;
	assign write_index  = res_s2.write_index;
	assign frame_done   = res_s2.frame_done;
	assign frame_length = res_s2.frame_length;

endmodule

// ===== hdl/fed_step.sv =====
// Destuffing decision for one byte: next deframer state and the result item.
`timescale 1ns / 1ps

module fed_step (
	input  logic                 [7:0] rx_byte,
	input  fed_pkg::fed_state_t        cur,
	output fed_pkg::fed_state_t        nxt,
	output fed_pkg::fed_result_t       res
);

	logic                      full;
	logic                      store;
	logic [7:0]                val;
	logic [fed_pkg::FILL_W-1:0] f;
	logic                      open;
	logic                      esc;
	logic                      drop;
	logic                      done;
	logic [fed_pkg::FILL_W-1:0] len;

	always_comb begin
		full  = (cur.fill == fed_pkg::FILL_W'(fed_pkg::FRAME_BYTES));
		// buffer full: abandon before handling the byte
		f     = full ? '0 : cur.fill;
		open  = full ? 1'b0 : cur.open;
		esc   = full ? 1'b0 : cur.esc;
		drop  = full && (cur.fill != '0);
		done  = 1'b0;
		len   = '0;
		store = 1'b0;
		val   = 8'h00;

		if (rx_byte == fed_pkg::FLAG_BYTE) begin
			if (open) begin
				if (f != '0) begin
					done = 1'b1;
					len  = f;
					f    = '0;
					open = 1'b0;
				end
				esc = 1'b0;
			end else begin
				// opening flag; pending escape is kept
				drop = drop | (f != '0);
				f    = '0;
				open = 1'b1;
			end
		end else if (rx_byte == fed_pkg::ESC_BYTE) begin
			if (esc) begin
				drop = drop | (f != '0);
				f    = '0;
				open = 1'b0;
				esc  = 1'b0;
			end else begin
				esc = 1'b1;
			end
		end else if (rx_byte == fed_pkg::ESC_CODE_ESC || rx_byte == fed_pkg::ESC_CODE_FLAG) begin
			if (esc) begin
				val = (rx_byte == fed_pkg::ESC_CODE_ESC) ? fed_pkg::ESC_BYTE : fed_pkg::FLAG_BYTE;
				esc = 1'b0;
			end else begin
				val = rx_byte;
			end
			store = 1'b1;
		end else begin
			if (esc) begin
				drop = drop | (f != '0);
				f    = '0;
				open = 1'b0;
				esc  = 1'b0;
			end else begin
				val   = rx_byte;
				store = 1'b1;
			end
		end

		res.dropped      = drop;
		res.stored       = store;
		res.data_byte    = store ? val : 8'h00;
		res.write_index  = store ? fed_pkg::INDEX_W'(f) : '0;
		res.frame_done   = done;
		res.frame_length = fed_pkg::LENGTH_W'(len);

		nxt.fill = store ? (f + fed_pkg::FILL_W'(1)) : f;
		nxt.open = open;
		nxt.esc  = esc;
	end

endmodule

// ===== hdl/fed_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
`timescale 1ns / 1ps

module fed_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          dropped,
	input logic                          stored,
	input logic [7:0]                    data_byte,
	input logic [fed_pkg::INDEX_W-1:0]   write_index,
	input logic                          frame_done,
	input logic [fed_pkg::LENGTH_W-1:0]  frame_length
);

	// a result held under stall keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stored) && $stable(data_byte)
		&& $stable(write_index) && $stable(frame_done) && $stable(frame_length))
		else $error("result changed while stalled");

	// a closing flag never stores a byte and always reports a nonzero length
	a_done_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> !stored && frame_length != '0)
		else $error("bad frame completion");

	a_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> frame_length == '0)
		else $error("length without completion");

	a_idle_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stored |-> data_byte == 8'h00 && write_index == '0)
		else $error("data without store");

	// an abandon clears the fill, so it cannot also complete a frame
	a_drop_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> !frame_done)
		else $error("drop and completion together");

endmodule

bind flag_escape_deframer_core fed_checker u_fed_checker (.*);
